@@ design/sequential_list_engine_top_assert.svh @@
// ----------------------------------------------------------------------------
// Sequential list engine assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_ASSERT_SVH

// Clocked check, switched off while reset is held
`define SLE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset
`define SLE_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// Sequential list engine package
// Operation and result codes, field widths, controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  // Transaction field widths
  localparam int unsigned POS_W  = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned SIZE_W = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_SHOW   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_DONE     = 3'd0,
    KIND_BADPOS   = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_NOTFOUND = 3'd3,
    KIND_MATCH    = 3'd4,
    KIND_ELEMENT  = 3'd5
  } kind_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic  accept;
    logic  shift_start;
    logic  shift_rd;
    logic  scan_start;
    logic  scan_rd;
    logic  scan_take;
    logic  place;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  kind_set;
    kind_e kind;
    logic  resp_load;
    logic  final_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic bad_pos;
    logic full;
    logic no_shift;
    logic count_zero;
    logic rd_end;
    logic scan_last;
    logic hit;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ design/sle_if.sv @@
// ----------------------------------------------------------------------------
// Sequential list engine channels
// Valid/ready interfaces for the operation and result streams.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_in_if;
  logic                              valid;
  logic                              ready;
  sle_pkg::op_e                      op;
  logic [sle_pkg::POS_W-1:0]         pos;
  logic signed [sle_pkg::VAL_W-1:0]  value;

  modport source (output valid, output op, output pos, output value, input ready);
  modport sink   (input valid, input op, input pos, input value, output ready);
endinterface

interface sle_out_if;
  logic                              valid;
  logic                              ready;
  sle_pkg::kind_e                    kind;
  logic [sle_pkg::IDX_W-1:0]         index;
  logic signed [sle_pkg::VAL_W-1:0]  item;
  logic [sle_pkg::SIZE_W-1:0]        size_now;
  logic                              last;

  modport source (output valid, output kind, output index, output item,
                  output size_now, output last, input ready);
  modport sink   (input valid, input kind, input index, input item,
                  input size_now, input last, output ready);
endinterface

`default_nettype wire

@@ design/sle_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sequential list engine controller
// One-hot sequencer issuing shift, scan and response commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sle_pkg::sts_t sts_i,
  output sle_pkg::cmd_t      cmd_o
);
  import sle_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_SHIFT   = 9'b000000100,
    S_DRAIN   = 9'b000001000,
    S_PLACE   = 9'b000010000,
    S_SCAN_RD = 9'b000100000,
    S_SCAN    = 9'b001000000,
    S_FINAL   = 9'b010000000,
    S_RESP    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence one transaction
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.bad_pos) begin
              cmd_o.kind_set = 1'b1;
              cmd_o.kind     = KIND_BADPOS;
              state_d        = S_RESP;
            end else if (sts_i.full) begin
              cmd_o.kind_set = 1'b1;
              cmd_o.kind     = KIND_FULL;
              state_d        = S_RESP;
            end else if (sts_i.no_shift) begin
              state_d = S_PLACE;
            end else begin
              cmd_o.shift_start = 1'b1;
              state_d           = S_SHIFT;
            end
          end
          OP_DELETE: begin
            if (sts_i.bad_pos) begin
              cmd_o.kind_set = 1'b1;
              cmd_o.kind     = KIND_BADPOS;
              state_d        = S_RESP;
            end else if (sts_i.no_shift) begin
              cmd_o.cnt_dec  = 1'b1;
              cmd_o.kind_set = 1'b1;
              cmd_o.kind     = KIND_DONE;
              state_d        = S_RESP;
            end else begin
              cmd_o.shift_start = 1'b1;
              state_d           = S_SHIFT;
            end
          end
          OP_SEARCH: begin
            cmd_o.kind_set = 1'b1;
            cmd_o.kind     = KIND_NOTFOUND;
            if (sts_i.count_zero) begin
              state_d = S_RESP;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN_RD;
            end
          end
          OP_SHOW: begin
            cmd_o.kind_set = 1'b1;
            cmd_o.kind     = KIND_DONE;
            if (sts_i.count_zero) begin
              state_d = S_RESP;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SHIFT: begin
        cmd_o.shift_rd = 1'b1;
        if (sts_i.rd_end) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.op == OP_INSERT) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.cnt_dec  = 1'b1;
          cmd_o.kind_set = 1'b1;
          cmd_o.kind     = KIND_DONE;
          state_d        = S_RESP;
        end
      end
      S_PLACE: begin
        cmd_o.place    = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        cmd_o.kind_set = 1'b1;
        cmd_o.kind     = KIND_DONE;
        state_d        = S_RESP;
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN;
      end
      S_SCAN: begin
        // advance unless a hit must push the pending entry into a busy slot
        if (!sts_i.hit || !sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.scan_take = 1'b1;
          if (sts_i.scan_last) begin
            state_d = S_FINAL;
          end else begin
            cmd_o.scan_rd = 1'b1;
          end
        end
      end
      S_FINAL: begin
        if (sts_i.out_free) begin
          if (sts_i.pend_valid) begin
            cmd_o.final_load = 1'b1;
          end else begin
            cmd_o.resp_load = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/sle_datapath.sv @@
// ----------------------------------------------------------------------------
// Sequential list engine datapath
// Entry memory, shift write-back, scan pending slot and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_datapath #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire sle_pkg::cmd_t                    cmd_i,
  output sle_pkg::sts_t                         sts_o,
  input  wire sle_pkg::op_e                     op_i,
  input  wire logic [sle_pkg::POS_W-1:0]        pos_i,
  input  wire logic signed [sle_pkg::VAL_W-1:0] value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output sle_pkg::kind_e                        kind_o,
  output logic [sle_pkg::IDX_W-1:0]             index_o,
  output logic signed [sle_pkg::VAL_W-1:0]      item_o,
  output logic [sle_pkg::SIZE_W-1:0]            size_now_o,
  output logic                                  last_o
);
  import sle_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int unsigned IXW  = (AW > IDX_W) ? AW : IDX_W;
  localparam int unsigned SXW  = (CW > SIZE_W) ? CW : SIZE_W;

  // Latched transaction
  op_e                op_q;
  logic [POS_W-1:0]   pos_q;
  logic [VAL_W-1:0]   val_q;
  kind_e              kind_q;

  // List state
  logic [CW-1:0]      count_q;
  logic [VAL_W-1:0]   mem [CAPACITY];
  logic [VAL_W-1:0]   rdata_q;
  logic [AW-1:0]      rd_addr_q;
  logic [AW-1:0]      idx_q;
  logic               wb_valid_q;
  logic [AW-1:0]      wb_addr_q;

  // Scan pending entry
  logic               pend_valid_q;
  logic [AW-1:0]      pend_idx_q;
  logic [VAL_W-1:0]   pend_item_q;

  // Result register
  logic               out_valid_q;
  kind_e              out_kind_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [VAL_W-1:0]   out_item_q;
  logic [SIZE_W-1:0]  out_size_q;
  logic               out_last_q;

  logic [CMPW-1:0]    pos_x, pos1_x, cnt_x;
  logic [CW-1:0]      cnt_m1;
  logic [AW-1:0]      pos_a;
  logic [IXW-1:0]     pend_idx_x;
  logic [SXW-1:0]     count_x;
  logic               rd_en, wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VAL_W-1:0]   wr_data;
  logic               hit;
  logic               out_free;
  logic               push_pend;
  kind_e              ent_kind;

  // Position and count compares
  always_comb begin
    pos_x      = CMPW'(pos_q);
    pos1_x     = pos_x + CMPW'(1);
    cnt_x      = CMPW'(count_q);
    cnt_m1     = count_q - CW'(1);
    pos_a      = pos_q[AW-1:0];
    pend_idx_x = IXW'(pend_idx_q);
    count_x    = SXW'(count_q);
    hit        = (op_q == OP_SHOW) || (rdata_q == val_q);
    out_free   = !out_valid_q || out_ready_i;
    push_pend  = cmd_i.scan_take && hit && pend_valid_q;
    ent_kind   = (op_q == OP_SHOW) ? KIND_ELEMENT : KIND_MATCH;
  end

  // Status towards the controller
  always_comb begin
    sts_o            = '0;
    sts_o.op         = op_q;
    sts_o.full       = (count_q == CW'(CAPACITY));
    sts_o.count_zero = (count_q == '0);
    sts_o.scan_last  = (idx_q == cnt_m1[AW-1:0]);
    sts_o.hit        = hit;
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
    case (op_q)
      OP_INSERT: begin
        sts_o.bad_pos  = (pos_x > cnt_x);
        sts_o.no_shift = (pos_x == cnt_x);
        sts_o.rd_end   = (rd_addr_q == pos_a);
      end
      OP_DELETE: begin
        sts_o.bad_pos  = (pos_x >= cnt_x);
        sts_o.no_shift = (pos1_x == cnt_x);
        sts_o.rd_end   = (rd_addr_q == cnt_m1[AW-1:0]);
      end
      default: begin
        sts_o.bad_pos  = 1'b0;
        sts_o.no_shift = 1'b0;
        sts_o.rd_end   = 1'b0;
      end
    endcase
  end

  // Memory port selection: shift write-back or new value placement
  always_comb begin
    rd_en   = cmd_i.shift_rd || cmd_i.scan_rd;
    wr_en   = wb_valid_q || cmd_i.place;
    wr_addr = cmd_i.place ? pos_a : wb_addr_q;
    wr_data = cmd_i.place ? val_q : rdata_q;
  end

  // Entry memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr_q];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      wb_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      wb_valid_q <= cmd_i.shift_rd;
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= cnt_m1;
      end
      if (cmd_i.accept || cmd_i.final_load) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.scan_take && hit) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.resp_load || cmd_i.final_load || push_pend) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_i;
      pos_q <= pos_i;
      val_q <= value_i;
    end
    if (cmd_i.kind_set) begin
      kind_q <= cmd_i.kind;
    end
    // walk addresses: insert reads downwards, delete upwards, scan from zero
    if (cmd_i.shift_start) begin
      rd_addr_q <= (op_q == OP_INSERT) ? cnt_m1[AW-1:0] : pos_a + AW'(1);
    end else if (cmd_i.scan_start) begin
      rd_addr_q <= '0;
    end else if (cmd_i.shift_rd) begin
      if (op_q == OP_INSERT) begin
        rd_addr_q <= rd_addr_q - AW'(1);
        wb_addr_q <= rd_addr_q + AW'(1);
      end else begin
        rd_addr_q <= rd_addr_q + AW'(1);
        wb_addr_q <= rd_addr_q - AW'(1);
      end
    end else if (cmd_i.scan_rd) begin
      rd_addr_q <= rd_addr_q + AW'(1);
    end
    if (cmd_i.scan_rd) begin
      idx_q <= rd_addr_q;
    end
    if (cmd_i.scan_take && hit) begin
      pend_idx_q  <= idx_q;
      pend_item_q <= rdata_q;
    end
    // load the result register, size captured with it so a stall holds it
    if (cmd_i.resp_load) begin
      out_kind_q <= kind_q;
      out_idx_q  <= '0;
      out_item_q <= '0;
      out_size_q <= count_x[SIZE_W-1:0];
      out_last_q <= 1'b1;
    end else if (cmd_i.final_load || push_pend) begin
      out_kind_q <= ent_kind;
      out_idx_q  <= pend_idx_x[IDX_W-1:0];
      out_item_q <= pend_item_q;
      out_size_q <= count_x[SIZE_W-1:0];
      out_last_q <= cmd_i.final_load;
    end
  end

  // Drive the result channel
  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign index_o     = out_idx_q;
  assign item_o      = $signed(out_item_q);
  assign size_now_o  = out_size_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

@@ design/sequential_list_engine_top.sv @@
// Insert: decode, shift, drain, place, response; with nothing to move, decode
// goes straight to place. Delete: decode, shift, drain, response. Bad position,
// full or a delete with nothing to move answer from decode. Search/show: results
// follow the scan, at most one per cycle. One transaction at a time; the single
// read port walks one entry per cycle, a scan waiting on a stalled result.
// Reset: entry count cleared; entry storage is left unwritten, no clear pass.
// ----------------------------------------------------------------------------
// Sequential list engine top level
// Ordered list with insert, delete, search and show over valid/ready channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sequential_list_engine_top #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sle_in_if.sink     in_i,
  sle_out_if.source  out_o
);
  import sle_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  sle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (in_i.op),
    .pos_i       (in_i.pos),
    .value_i     (in_i.value),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .kind_o      (out_o.kind),
    .index_o     (out_o.index),
    .item_o      (out_o.item),
    .size_now_o  (out_o.size_now),
    .last_o      (out_o.last)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

@@ design/sle_checker.sv @@
// ----------------------------------------------------------------------------
// Sequential list engine port checker
// Port-level checks on result framing and handshake, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequential_list_engine_top_assert.svh"

module sle_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_i,
  input wire logic                             out_valid_i,
  input wire logic                             out_ready_i,
  input wire sle_pkg::kind_e                   kind_i,
  input wire logic [sle_pkg::IDX_W-1:0]        index_i,
  input wire logic signed [sle_pkg::VAL_W-1:0] item_i,
  input wire logic [sle_pkg::SIZE_W-1:0]       size_now_i,
  input wire logic                             last_i
);
  import sle_pkg::*;

  // No result shown while reset is held
  `SLE_ASSERT_RST(a_rst_no_result, clk_i, !rst_ni |-> !out_valid_i, "result valid in reset")

  // One transaction at a time: busy right after acceptance
  `SLE_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i, "accepted twice in a row")

  // Status results always close their transaction
  `SLE_ASSERT(a_status_last, clk_i, rst_ni, out_valid_i && kind_i != KIND_MATCH && kind_i != KIND_ELEMENT |-> last_i, "status result without last")

  // Status results carry no entry
  `SLE_ASSERT(a_status_empty, clk_i, rst_ni, out_valid_i && (kind_i == KIND_DONE || kind_i == KIND_BADPOS || kind_i == KIND_FULL || kind_i == KIND_NOTFOUND) |-> index_i == '0 && item_i == '0, "status result carries entry")

  // Stalled result holds
  `SLE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(index_i) && $stable(item_i) && $stable(size_now_i) && $stable(last_i), "stalled result changed")

endmodule

bind sequential_list_engine_top sle_checker u_sle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.kind),
  .index_i     (out_o.index),
  .item_i      (out_o.item),
  .size_now_i  (out_o.size_now),
  .last_i      (out_o.last)
);

`default_nettype wire
